// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ant, con) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ant, con) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/bti_pkg.sv =====
// Shared types and constants of the bilinear table interpolator.
package bti_pkg;

   localparam int CsrDataWidth = 16;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_STEP_LENGTH = 2'd0,
      CSR_HALF_COLS   = 2'd1,
      CSR_HALF_ROWS   = 2'd2,
      CSR_TABLE_READY = 2'd3
   } csr_index_type;

   localparam logic [15:0] StepReset  = 16'd256;
   localparam logic [5:0]  HalfReset  = 6'd32;
   localparam logic        ReadyReset = 1'b0;

   typedef struct packed {
      opcode_type         opcode;
      logic [5:0]         col_index;
      logic [5:0]         row_index;
      logic [15:0]        entry_value;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_z;
   } req_type;

   typedef struct packed {
      logic [15:0] interp_value;
      logic        in_range;
   } rsp_type;

endpackage

// ===== rtl/bilinear_table_interpolator_top.sv =====
// Top level of the pipelined bilinear table interpolator.
//
// The block takes one word per cycle on the req_ channel while req_stall is
// low. A write word stores entry_value at (col_index, row_index) of the table
// and gives no result. A lookup word floor-divides both offsets by the grid
// step, takes the quotient as the lower cell and the scaled remainder as a
// blend weight, and returns one rsp_ word with the bilinear blend of the four
// neighboring entries. The divider resolves one quotient bit per stage over
// 16 offset bits, then has one sign fixup stage and WEIGHT_FRAC_BITS weight
// bit stages, followed by address, table read, multiply and sum stages. The
// table sits in four banks split by the parity of column and row, so all four
// corners are read in the same cycle. When the receiver raises rsp_stall while
// a result is waiting, the whole pipeline holds and req_stall rises; nothing
// is lost or repeated. Synchronous reset clears all valid bits and sets
// the registers to their defaults; the table contents are undefined until
// written. The user must write registers through csr_ only while no word
// is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module bilinear_table_interpolator_top #(
   parameter int MAX_HALF         = 32,
   parameter int WEIGHT_FRAC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bti_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bti_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_enable,
   input  bti_pkg::csr_index_type            csr_index,
   input  logic [bti_pkg::CsrDataWidth-1:0]  csr_write_data
);

   localparam int W          = WEIGHT_FRAC_BITS;
   localparam int SIDE       = 2 * MAX_HALF;
   localparam int SB         = $clog2(SIDE);
   localparam int HB         = SB - 1;
   localparam int BA         = 2 * HB;
   localparam int BANK_DEPTH = (SIDE / 2) * (SIDE / 2);
   localparam int HW         = $clog2(MAX_HALF + 1);
   localparam int DIV_BITS   = 16;
   localparam int FIX_STAGE  = DIV_BITS + 1;
   localparam int DS         = DIV_BITS + 1 + W;
   localparam int QW         = 18;
   localparam int PW         = 2 * W + 2;
   localparam int TW         = PW + 16;
   localparam int AW         = TW + 2;

   typedef struct packed {
      logic                 valid;
      logic                 write;
      logic                 ok;
      logic [5:0]           col;
      logic [5:0]           row;
      logic [15:0]          entry;
      logic                 neg_x;
      logic                 neg_z;
      logic [15:0]          dvd_x;
      logic [15:0]          dvd_z;
      logic [16:0]          rem_x;
      logic [16:0]          rem_z;
      logic [15:0]          quo_x;
      logic [15:0]          quo_z;
      logic signed [QW-1:0] qx;
      logic signed [QW-1:0] qz;
   } div_type;

   typedef struct packed {
      logic                  valid;
      logic                  write;
      logic                  ok;
      logic                  wen;
      logic [1:0]            wbank;
      logic [BA-1:0]         waddr;
      logic [15:0]           entry;
      logic                  lc0;
      logic                  lr0;
      logic [3:0][BA-1:0]    raddr;
      logic [3:0][PW-1:0]    wp;
   } addr_type;

   typedef struct packed {
      logic               valid;
      logic               write;
      logic               ok;
      logic               lc0;
      logic               lr0;
      logic [3:0][PW-1:0] wp;
   } read_type;

   typedef struct packed {
      logic               valid;
      logic               write;
      logic               ok;
      logic [3:0][TW-1:0] term;
   } mult_type;

   logic [15:0]      step_ff;
   logic [5:0]       half_cols_ff;
   logic [5:0]       half_rows_ff;
   logic             ready_ff;
   logic             pipe_advance;
   logic [HW-1:0]    nx;
   logic [HW-1:0]    nz;
   div_type          d_ff [0:DS];
   div_type          d_in [0:DS];
   addr_type         a_ff;
   addr_type         a_in;
   read_type         r_ff;
   logic [15:0]      rd_ff [4];
   logic [15:0]      bank_mem [4][BANK_DEPTH];
   mult_type         m_ff;
   mult_type         m_in;
   logic             rsp_valid_ff;
   bti_pkg::rsp_type rsp_data_ff;
   bti_pkg::rsp_type rsp_data_in;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [17:0] div_step(input logic [16:0] shifted,
                                            input logic [15:0] divisor);
      logic ge;
      ge = shifted >= {1'b0, divisor};
      return {ge, ge ? shifted - {1'b0, divisor} : shifted};
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= bti_pkg::StepReset;
         half_cols_ff <= bti_pkg::HalfReset;
         half_rows_ff <= bti_pkg::HalfReset;
         ready_ff     <= bti_pkg::ReadyReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bti_pkg::CSR_STEP_LENGTH: step_ff      <= csr_write_data;
            bti_pkg::CSR_HALF_COLS:   half_cols_ff <= csr_write_data[5:0];
            bti_pkg::CSR_HALF_ROWS:   half_rows_ff <= csr_write_data[5:0];
            bti_pkg::CSR_TABLE_READY: ready_ff     <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Half extents above the table size saturate to it.
   assign nx = (32'(half_cols_ff) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_cols_ff);
   assign nz = (32'(half_rows_ff) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_rows_ff);

   // The pipeline moves as a whole whenever the output register can take a word.
   assign pipe_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = !pipe_advance;

   // Divider pipeline: entry stage, one quotient bit per stage, sign fixup
   // with range check, then one weight bit per stage.
   always_comb begin
      logic [17:0]          sx;
      logic [17:0]          sz;
      logic signed [QW-1:0] mx;
      logic signed [QW-1:0] mz;
      logic signed [QW-1:0] nxs;
      logic signed [QW-1:0] nzs;
      div_type              s;
      nxs = signed'(QW'(nx));
      nzs = signed'(QW'(nz));
      d_in[0]       = '0;
      d_in[0].valid = req_valid;
      d_in[0].write = req_data.opcode == bti_pkg::OP_WRITE;
      d_in[0].ok    = (req_data.opcode == bti_pkg::OP_LOOKUP) && ready_ff && (step_ff != 16'd0);
      d_in[0].col   = req_data.col_index;
      d_in[0].row   = req_data.row_index;
      d_in[0].entry = req_data.entry_value;
      d_in[0].neg_x = req_data.offset_x[15];
      d_in[0].neg_z = req_data.offset_z[15];
      d_in[0].dvd_x = req_data.offset_x[15] ? 16'(-req_data.offset_x) : req_data.offset_x;
      d_in[0].dvd_z = req_data.offset_z[15] ? 16'(-req_data.offset_z) : req_data.offset_z;
      for (int k = 1; k <= DS; k++) begin
         s       = d_ff[k-1];
         d_in[k] = s;
         if (k <= DIV_BITS) begin
            sx = div_step({s.rem_x[15:0], s.dvd_x[15]}, step_ff);
            sz = div_step({s.rem_z[15:0], s.dvd_z[15]}, step_ff);
            d_in[k].dvd_x = {s.dvd_x[14:0], 1'b0};
            d_in[k].dvd_z = {s.dvd_z[14:0], 1'b0};
            d_in[k].rem_x = sx[16:0];
            d_in[k].rem_z = sz[16:0];
            d_in[k].quo_x = {s.quo_x[14:0], sx[17]};
            d_in[k].quo_z = {s.quo_z[14:0], sz[17]};
         end else if (k == FIX_STAGE) begin
            // Turn the magnitude quotient into a floor quotient.
            mx = signed'(QW'(s.quo_x));
            mz = signed'(QW'(s.quo_z));
            if (s.neg_x) begin
               mx = (s.rem_x != 17'd0) ? -mx - QW'(1) : -mx;
               d_in[k].rem_x = (s.rem_x != 17'd0) ? {1'b0, step_ff} - s.rem_x : 17'd0;
            end
            if (s.neg_z) begin
               mz = (s.rem_z != 17'd0) ? -mz - QW'(1) : -mz;
               d_in[k].rem_z = (s.rem_z != 17'd0) ? {1'b0, step_ff} - s.rem_z : 17'd0;
            end
            d_in[k].qx    = mx;
            d_in[k].qz    = mz;
            d_in[k].quo_x = '0;
            d_in[k].quo_z = '0;
            d_in[k].ok    = s.ok && (mx >= -nxs) && (mx + QW'(1) < nxs)
                                 && (mz >= -nzs) && (mz + QW'(1) < nzs);
         end else begin
            sx = div_step({s.rem_x[15:0], 1'b0}, step_ff);
            sz = div_step({s.rem_z[15:0], 1'b0}, step_ff);
            d_in[k].rem_x = sx[16:0];
            d_in[k].rem_z = sz[16:0];
            d_in[k].quo_x = {s.quo_x[14:0], sx[17]};
            d_in[k].quo_z = {s.quo_z[14:0], sz[17]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DS; k++) begin
            d_ff[k].valid <= 1'b0;
         end
      end else if (pipe_advance) begin
         d_ff <= d_in;
      end
   end

   // Address stage: bank addresses of the four corners, write address and
   // the four weight products.
   always_comb begin
      div_type              f;
      logic signed [QW-1:0] lc_full;
      logic signed [QW-1:0] lr_full;
      logic [SB-1:0]        lc;
      logic [SB-1:0]        lr;
      logic [SB-1:0]        lc1;
      logic [SB-1:0]        lr1;
      logic [SB-1:0]        csel;
      logic [SB-1:0]        rsel;
      logic [SB-1:0]        wc;
      logic [SB-1:0]        wr;
      logic [W:0]           one;
      logic [W:0]           wx;
      logic [W:0]           wz;
      logic [W:0]           ix;
      logic [W:0]           iz;
      f       = d_ff[DS];
      lc_full = f.qx + signed'(QW'(nx));
      lr_full = f.qz + signed'(QW'(nz));
      lc      = lc_full[SB-1:0];
      lr      = lr_full[SB-1:0];
      lc1     = lc + SB'(1);
      lr1     = lr + SB'(1);
      wc      = SB'(f.col);
      wr      = SB'(f.row);
      one     = (W + 1)'(1) << W;
      wx      = {1'b0, f.quo_x[W-1:0]};
      wz      = {1'b0, f.quo_z[W-1:0]};
      ix      = one - wx;
      iz      = one - wz;
      a_in       = '0;
      a_in.valid = f.valid;
      a_in.write = f.write;
      a_in.ok    = f.ok;
      a_in.wen   = f.write && (32'(f.col) < SIDE) && (32'(f.row) < SIDE);
      a_in.wbank = {wc[0], wr[0]};
      a_in.waddr = {wc[SB-1:1], wr[SB-1:1]};
      a_in.entry = f.entry;
      a_in.lc0   = lc[0];
      a_in.lr0   = lr[0];
      for (int b = 0; b < 4; b++) begin
         csel = (lc[0] == b[1]) ? lc : lc1;
         rsel = (lr[0] == b[0]) ? lr : lr1;
         a_in.raddr[b] = {csel[SB-1:1], rsel[SB-1:1]};
      end
      a_in.wp[0] = PW'(ix) * PW'(iz);
      a_in.wp[1] = PW'(wx) * PW'(iz);
      a_in.wp[2] = PW'(wx) * PW'(wz);
      a_in.wp[3] = PW'(ix) * PW'(wz);
   end

   // Table banks, indexed by {column parity, row parity}.
   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int b = 0; b < 4; b++) begin
            if (a_ff.valid && a_ff.wen && (a_ff.wbank == 2'(b))) begin
               bank_mem[b][a_ff.waddr] <= a_ff.entry;
            end
            rd_ff[b] <= bank_mem[b][a_ff.raddr[b]];
         end
      end
   end

   // Multiply stage: route each bank to its corner and scale by its weight.
   always_comb begin
      logic [1:0] bsel [4];
      bsel[0] = {r_ff.lc0, r_ff.lr0};
      bsel[1] = {~r_ff.lc0, r_ff.lr0};
      bsel[2] = {~r_ff.lc0, ~r_ff.lr0};
      bsel[3] = {r_ff.lc0, ~r_ff.lr0};
      m_in       = '0;
      m_in.valid = r_ff.valid;
      m_in.write = r_ff.write;
      m_in.ok    = r_ff.ok;
      for (int j = 0; j < 4; j++) begin
         m_in.term[j] = TW'(r_ff.wp[j]) * TW'(rd_ff[bsel[j]]);
      end
   end

   // Sum, round to nearest and saturate; a lookup that is not ok gives zero.
   always_comb begin
      logic [AW-1:0] acc;
      logic [AW-1:0] shifted;
      acc = AW'(m_ff.term[0]) + AW'(m_ff.term[1]) + AW'(m_ff.term[2])
          + AW'(m_ff.term[3]) + (AW'(1) << (2 * W - 1));
      shifted = acc >> (2 * W);
      rsp_data_in.in_range     = m_ff.ok;
      rsp_data_in.interp_value = !m_ff.ok ? 16'd0 :
                                 (shifted > AW'(16'hFFFF)) ? 16'hFFFF : shifted[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid   <= 1'b0;
         r_ff.valid   <= 1'b0;
         m_ff.valid   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         a_ff         <= a_in;
         r_ff.valid   <= a_ff.valid;
         r_ff.write   <= a_ff.write;
         r_ff.ok      <= a_ff.ok;
         r_ff.lc0     <= a_ff.lc0;
         r_ff.lr0     <= a_ff.lr0;
         r_ff.wp      <= a_ff.wp;
         m_ff         <= m_in;
         rsp_valid_ff <= m_ff.valid && !m_ff.write;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPL(a_zero_out_of_range, rsp_valid_ff && !rsp_data_ff.in_range, rsp_data_ff.interp_value == 16'd0)
   `ASSERT_NEXT(a_hold_on_stall, !pipe_advance, $stable(m_ff.valid) && $stable(rsp_valid_ff))
   `ASSERT_NEXT(a_lookup_delivered, pipe_advance && m_ff.valid && !m_ff.write, rsp_valid_ff)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the bilinear table interpolator.
`timescale 1ns / 100ps

module tb;

   localparam int MaxHalf   = 32;
   localparam int WeightW   = 12;
   localparam int SideLen   = 2 * MaxHalf;
   localparam int Latency   = WeightW + 21;
   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   bti_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   bti_pkg::rsp_type rsp_data;
   logic csr_write_enable;
   bti_pkg::csr_index_type csr_index;
   logic [bti_pkg::CsrDataWidth-1:0] csr_write_data;

   bilinear_table_interpolator_top #(
      .MAX_HALF(MaxHalf),
      .WEIGHT_FRAC_BITS(WeightW)
   ) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // The clock runs with a 2 ns period.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Shadow copy of the table and registers used to predict each lookup.
   logic [15:0] shadow_table [SideLen*SideLen];
   bit          shadow_written [SideLen*SideLen];
   logic [15:0] shadow_step;
   logic [5:0]  shadow_half_cols;
   logic [5:0]  shadow_half_rows;
   logic        shadow_ready;

   bti_pkg::rsp_type expected_lookups[$];
   int      error_count;
   int      cycle_count;
   int      sent_count;
   bit      long_hold;

   // Floor division of one offset by the step; gives the lower cell and weight.
   function automatic void floor_split(input logic signed [15:0] offset,
                                       input logic [15:0] step,
                                       output int lower, output int weight);
      int q;
      int r;
      q = offset / int'(step);
      r = offset - q * int'(step);
      if (r < 0) begin
         q = q - 1;
         r = r + int'(step);
      end
      lower = q;
      weight = int'((longint'(r) << WeightW) / longint'(step));
   endfunction

   // Computes the blended value a lookup word must produce.
   function automatic bti_pkg::rsp_type blend_lookup(input bti_pkg::req_type word);
      bti_pkg::rsp_type result;
      int nx, nz, qx, qz, wx, wz, lc, lr;
      longint unsigned one, acc;
      result = '0;
      if (!shadow_ready || shadow_step == 0) return result;
      nx = (shadow_half_cols > MaxHalf) ? MaxHalf : shadow_half_cols;
      nz = (shadow_half_rows > MaxHalf) ? MaxHalf : shadow_half_rows;
      floor_split(word.offset_x, shadow_step, qx, wx);
      floor_split(word.offset_z, shadow_step, qz, wz);
      if (qx < -nx || qx + 1 >= nx || qz < -nz || qz + 1 >= nz) return result;
      lc = qx + nx;
      lr = qz + nz;
      one = 1 << WeightW;
      acc = (one - wx) * (one - wz) * shadow_table[lc*SideLen + lr]
          + wx * (one - wz) * shadow_table[(lc+1)*SideLen + lr]
          + wx * wz * shadow_table[(lc+1)*SideLen + lr + 1]
          + (one - wx) * wz * shadow_table[lc*SideLen + lr + 1];
      acc = (acc + (longint'(1) << (2*WeightW - 1))) >> (2*WeightW);
      if (acc > 65535) acc = 65535;
      result.interp_value = acc[15:0];
      result.in_range = 1'b1;
      return result;
   endfunction

   // True when a lookup would read only entries that have been written, or none.
   function automatic bit lookup_reads_written(input bti_pkg::req_type word);
      int nx, nz, qx, qz, wx, wz, lc, lr;
      if (!shadow_ready || shadow_step == 0) return 1;
      nx = (shadow_half_cols > MaxHalf) ? MaxHalf : shadow_half_cols;
      nz = (shadow_half_rows > MaxHalf) ? MaxHalf : shadow_half_rows;
      floor_split(word.offset_x, shadow_step, qx, wx);
      floor_split(word.offset_z, shadow_step, qz, wz);
      if (qx < -nx || qx + 1 >= nx || qz < -nz || qz + 1 >= nz) return 1;
      lc = qx + nx;
      lr = qz + nz;
      return shadow_written[lc*SideLen + lr] && shadow_written[(lc+1)*SideLen + lr]
          && shadow_written[(lc+1)*SideLen + lr + 1]
          && shadow_written[lc*SideLen + lr + 1];
   endfunction

   // Sends one word, holding it until the block accepts it, and records
   // its effect on the shadow state. Gaps between bursts are random.
   int burst_left;
   task automatic send_word(input bti_pkg::req_type word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (word.opcode == bti_pkg::OP_WRITE) begin
         shadow_table[word.col_index*SideLen + word.row_index] = word.entry_value;
         shadow_written[word.col_index*SideLen + word.row_index] = 1'b1;
      end else begin
         expected_lookups.push_back(blend_lookup(word));
      end
      burst_left--;
      sent_count++;
      @(negedge clock);
   endtask

   // Idles the sender and lets every expected result drain.
   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_lookups.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   task automatic write_csr(input bti_pkg::csr_index_type idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= 16'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         bti_pkg::CSR_STEP_LENGTH: shadow_step = 16'(value);
         bti_pkg::CSR_HALF_COLS:   shadow_half_cols = 6'(value);
         bti_pkg::CSR_HALF_ROWS:   shadow_half_rows = 6'(value);
         bti_pkg::CSR_TABLE_READY: shadow_ready = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic bti_pkg::req_type make_write(input int col, input int row,
                                                   input logic [15:0] value);
      bti_pkg::req_type word;
      word = '0;
      word.opcode = bti_pkg::OP_WRITE;
      word.col_index = 6'(col);
      word.row_index = 6'(row);
      word.entry_value = value;
      word.offset_x = 16'($urandom);
      word.offset_z = 16'($urandom);
      return word;
   endfunction

   function automatic bti_pkg::req_type make_lookup(input logic [15:0] x,
                                                    input logic [15:0] z);
      bti_pkg::req_type word;
      word = '0;
      word.opcode = bti_pkg::OP_LOOKUP;
      word.col_index = 6'($urandom);
      word.row_index = 6'($urandom);
      word.entry_value = 16'($urandom);
      word.offset_x = x;
      word.offset_z = z;
      return word;
   endfunction

   // Sends a lookup only when it touches written entries.
   task automatic send_lookup(input logic [15:0] x, input logic [15:0] z);
      bti_pkg::req_type word;
      word = make_lookup(x, z);
      if (lookup_reads_written(word)) send_word(word);
   endtask

   // Stored indexes that the load covers: both edges and a central band.
   function automatic bit in_load_set(input int idx);
      return (idx < 2) || (idx >= 24 && idx < 40) || (idx >= SideLen - 2);
   endfunction

   // Loads the edges and the center of the store with random values, with
   // a few extremes.
   task automatic test_table_load;
      for (int c = 0; c < SideLen; c++) begin
         for (int r = 0; r < SideLen; r++) begin
            if (in_load_set(c) && in_load_set(r)) begin
               case ($urandom_range(0, 9))
                  0: send_word(make_write(c, r, 16'hFFFF));
                  1: send_word(make_write(c, r, 16'h0000));
                  default: send_word(make_write(c, r, 16'($urandom)));
               endcase
            end
         end
      end
      drain();
   endtask

   // Lookups with the table not ready give zero and no in_range.
   task automatic test_not_ready;
      send_lookup(16'h0000, 16'h0000);
      send_lookup(16'h7FFF, 16'h8000);
      send_lookup(16'($urandom), 16'($urandom));
      drain();
   endtask

   // Directed extremes at the reset grid: corners, exact grid points,
   // the last valid cell and the first cell outside.
   task automatic test_directed;
      write_csr(bti_pkg::CSR_TABLE_READY, 1);
      send_lookup(16'h0000, 16'h0000);
      send_lookup(16'h7FFF, 16'h7FFF);
      send_lookup(16'h8000, 16'h8000);
      send_lookup(16'hFFFF, 16'h0001);
      send_lookup(16'd7935, 16'd7935);       // highest offset still in range
      send_lookup(16'd7936, 16'd0);          // upper corner just outside
      send_lookup(-16'sd8192, -16'sd8192);   // lowest cell
      send_lookup(-16'sd8193, 16'd0);        // one below the lowest cell
      send_lookup(16'd255, 16'd128);
      send_word(make_write(0, 0, 16'hFFFF));
      send_word(make_write(63, 63, 16'h0000));
      send_lookup(-16'sd8192, 16'd7935);
      drain();
      // Unit step: weights are always zero.
      write_csr(bti_pkg::CSR_STEP_LENGTH, 1);
      send_lookup(16'd5, -16'sd7);
      send_lookup(16'd31, 16'd30);
      send_lookup(16'd32, 16'd0);
      drain();
      // Largest step: every offset falls in cell 0 or -1.
      write_csr(bti_pkg::CSR_STEP_LENGTH, 16'hFFFF);
      send_lookup(16'h7FFF, 16'h8000);
      send_lookup(16'h0000, 16'hFFFF);
      drain();
      // Zero step turns off every lookup.
      write_csr(bti_pkg::CSR_STEP_LENGTH, 0);
      send_lookup(16'd0, 16'd0);
      send_lookup(16'd100, 16'd100);
      drain();
      // Halves of zero and above the maximum.
      write_csr(bti_pkg::CSR_STEP_LENGTH, 100);
      write_csr(bti_pkg::CSR_HALF_COLS, 0);
      send_lookup(16'd0, 16'd0);
      drain();
      write_csr(bti_pkg::CSR_HALF_COLS, 63);
      write_csr(bti_pkg::CSR_HALF_ROWS, 1);
      send_lookup(16'd50, -16'sd50);
      send_lookup(-16'sd3200, -16'sd1);
      send_lookup(16'd3099, 16'd0);
      drain();
   endtask

   // Random offsets under several register settings, with a long receiver
   // hold at the start of one phase so that the pipeline backs up.
   task automatic test_random;
      int step_choice [6] = '{1, 7, 100, 256, 1000, 65535};
      int base;
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(bti_pkg::CSR_STEP_LENGTH, step_choice[phase]);
         write_csr(bti_pkg::CSR_HALF_COLS, (phase == 2) ? 32 : $urandom_range(1, 40));
         write_csr(bti_pkg::CSR_HALF_ROWS, (phase == 3) ? 1 : $urandom_range(1, 40));
         write_csr(bti_pkg::CSR_TABLE_READY, (phase == 5) ? 0 : 1);
         if (phase == 3) long_hold = 1'b1;
         base = sent_count;
         while (sent_count - base < 80) begin
            logic [15:0] span;
            span = step_choice[phase] * 12 > 32767 ? 16'hFFFF
                 : 16'(step_choice[phase] * 12);
            if ($urandom_range(0, 9) == 0) begin
               send_word(make_write($urandom_range(0, 63), $urandom_range(0, 63),
                                    16'($urandom)));
            end else if ($urandom_range(0, 4) == 0) begin
               send_lookup(16'($urandom), 16'($urandom));
            end else begin
               send_lookup(16'($signed($urandom_range(0, 2*span)) - $signed(span)),
                           16'($signed($urandom_range(0, 2*span)) - $signed(span)));
            end
         end
         drain();
      end
   endtask

   // Receiver: stalls on its own random pattern, and once holds off for a
   // long stretch while the sender keeps offering words.
   initial begin
      int pattern;
      int hold_cycles;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 200) begin
               @(negedge clock);
               hold_cycles++;
            end
         end
         pattern = $urandom_range(0, 7);
         rsp_stall <= (pattern < 2) || ((cycle_count / 300) % 4 == 1 && pattern < 5);
         @(negedge clock);
      end
   end

   // Result checker: each accepted result is compared with the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lookups.size() == 0) begin
            $error("result with no expectation waiting: value %0h in_range %0b",
                   rsp_data.interp_value, rsp_data.in_range);
            error_count++;
         end else begin
            bti_pkg::rsp_type want;
            want = expected_lookups.pop_front();
            if (rsp_data.interp_value !== want.interp_value) begin
               $error("interp_value expected %0h actual %0h",
                      want.interp_value, rsp_data.interp_value);
               error_count++;
            end
            if (rsp_data.in_range !== want.in_range) begin
               $error("in_range expected %0b actual %0b", want.in_range, rsp_data.in_range);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      sent_count = 0;
      burst_left = 0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = bti_pkg::CSR_STEP_LENGTH;
      csr_write_data = '0;
      shadow_step = bti_pkg::StepReset;
      shadow_half_cols = bti_pkg::HalfReset;
      shadow_half_rows = bti_pkg::HalfReset;
      shadow_ready = bti_pkg::ReadyReset;
      foreach (shadow_written[i]) shadow_written[i] = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_not_ready();
      test_table_load();
      test_directed();
      test_random();
      drain();
      if (error_count == 0 && expected_lookups.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bti_pkg.sv
rtl/bilinear_table_interpolator_top.sv
tb/sv/tb.sv
